// ===== rtl/core/cdq_pkg.sv =====
package cdq_pkg;

  localparam int DefDepth     = 16;
  localparam int DefDataWidth = 32;

  localparam int CmdWidth     = 3;
  localparam int StatusWidth  = 2;
  localparam int CapWidth     = 5;
  localparam int ApbAddrWidth = 3;
  localparam int ApbDataWidth = 32;

  localparam logic [CapWidth-1:0] CapReset = CapWidth'(16);

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_REAR  = 3'd5
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // what every cell does with its entry this cycle
  typedef enum logic [1:0] {
    OP_HOLD       = 2'd0,
    OP_TAKE_LEFT  = 2'd1,
    OP_TAKE_RIGHT = 2'd2,
    OP_LOAD_TAIL  = 2'd3
  } cell_op_e;

  typedef enum logic {
    REG_CAPACITY = 1'b0
  } reg_idx_e;

endpackage

// ===== rtl/core/circular_deque_core.sv =====
// result strobe done_o rises in the cycle after a request is taken
// throughput: one request per cycle, busy_o never rises
// a front push or front pop shifts the whole row of cells, a rear push loads the tail cell, other requests hold
// reset: deque empty, capacity 16, stored data undefined
// results cannot be stalled by the receiver
module circular_deque_core #(
  parameter int DATA_WIDTH = cdq_pkg::DefDataWidth,
  parameter int DEPTH      = cdq_pkg::DefDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [cdq_pkg::CmdWidth-1:0]        cmd_i,
  input  logic [DATA_WIDTH-1:0]               value_in_i,
  output logic                                done_o,
  output logic                                ok_o,
  output logic [DATA_WIDTH-1:0]               value_out_o,
  output logic [cdq_pkg::StatusWidth-1:0]     status_o,
  output logic                                is_empty_o,
  output logic                                is_full_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cdq_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [cdq_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [cdq_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                pready
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [cdq_pkg::CapWidth-1:0] cap_q;
  logic [CntW-1:0]              cap_eff;
  logic [CntW-1:0]              count_q, count_d;
  logic                         cfg_sel, cfg_we;
  logic                         full, empty;
  logic                         accept;

  cdq_pkg::cell_op_e            op;
  logic                         ok_d;
  logic [DATA_WIDTH-1:0]        vout_d;
  cdq_pkg::status_e             status_d;

  logic                         done_q;
  logic                         ok_q, empty_q, full_q;
  logic [DATA_WIDTH-1:0]        vout_q;
  cdq_pkg::status_e             status_q;

  logic [DATA_WIDTH-1:0]        cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]        cell_tail [DEPTH];
  logic [DATA_WIDTH-1:0]        rear_val;

  // config port
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == cdq_pkg::REG_CAPACITY);
  assign cfg_we  = psel & penable & pwrite & pready & cfg_sel;
  assign prdata  = cfg_sel ? {{(cdq_pkg::ApbDataWidth - cdq_pkg::CapWidth){1'b0}}, cap_q}
                           : '0;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if ({{(32 - cdq_pkg::CapWidth){1'b0}}, cap_q} > 32'(DEPTH)) begin
      cap_eff = CntW'(DEPTH);
    end else begin
      cap_eff = CntW'(cap_q);
    end
  end

  assign full   = (count_q == cap_eff);
  assign empty  = (count_q == '0);
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // cell row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right, tail_in;
    if (k == 0) begin : g_first
      assign left    = value_in_i;
      assign tail_in = '0;
    end else begin : g_mid
      assign left    = cell_data[k-1];
      assign tail_in = cell_tail[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_next
      assign right = cell_data[k+1];
    end

    cdq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .DEPTH     (DEPTH),
      .IDX       (k)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .count_i(count_q),
      .value_i(value_in_i),
      .left_i (left),
      .right_i(right),
      .tail_i (tail_in),
      .data_o (cell_data[k]),
      .tail_o (cell_tail[k])
    );
  end

  assign rear_val = cell_tail[DEPTH-1];

  // command decode
  always_comb begin
    op       = cdq_pkg::OP_HOLD;
    count_d  = count_q;
    ok_d     = 1'b0;
    vout_d   = '0;
    status_d = cdq_pkg::ST_DONE;
    case (cmd_i)
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          status_d = cdq_pkg::ST_FULL;
        end else begin
          ok_d    = 1'b1;
          count_d = count_q + CntW'(1);
          op      = (cmd_i == cdq_pkg::CMD_PUSH_FRONT) ? cdq_pkg::OP_TAKE_LEFT
                                                       : cdq_pkg::OP_LOAD_TAIL;
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          ok_d    = 1'b1;
          count_d = count_q - CntW'(1);
          if (cmd_i == cdq_pkg::CMD_POP_FRONT) begin
            vout_d = cell_data[0];
            op     = cdq_pkg::OP_TAKE_RIGHT;
          end else begin
            vout_d = rear_val;
          end
        end
      end
      cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_REAR: begin
        if (empty) begin
          status_d = cdq_pkg::ST_EMPTY;
        end else begin
          ok_d   = 1'b1;
          vout_d = (cmd_i == cdq_pkg::CMD_PEEK_FRONT) ? cell_data[0] : rear_val;
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (!accept) begin
      op      = cdq_pkg::OP_HOLD;
      count_d = count_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= cdq_pkg::CapReset;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (cfg_we) begin
        cap_q   <= pwdata[cdq_pkg::CapWidth-1:0];
        count_q <= '0;
      end else begin
        count_q <= count_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q     <= ok_d;
      vout_q   <= vout_d;
      status_q <= status_d;
      empty_q  <= (count_d == '0);
      full_q   <= (count_d == cap_eff);
    end
  end

  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign value_out_o = vout_q;
  assign status_o    = status_q;
  assign is_empty_o  = empty_q;
  assign is_full_o   = full_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_eff)
    else $error("element count above capacity");

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (count_q == '0))
    else $error("capacity write did not clear the deque");

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without result strobe");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ok_o) |-> (status_o == cdq_pkg::ST_DONE))
    else $error("carried out request with refusal status");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(is_empty_o && is_full_o))
    else $error("empty and full both reported");

endmodule

// ===== rtl/core/cdq_cell.sv =====
module cdq_cell #(
  parameter int DATA_WIDTH = cdq_pkg::DefDataWidth,
  parameter int DEPTH      = cdq_pkg::DefDepth,
  parameter int IDX        = 0,
  localparam int CntW      = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  cdq_pkg::cell_op_e     op_i,
  input  logic [CntW-1:0]       count_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] tail_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tail_o
);

  localparam logic [CntW-1:0] MyIdx   = CntW'(IDX);
  localparam logic [CntW-1:0] NextIdx = CntW'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  is_tail;

  always_comb begin
    data_d = data_q;
    case (op_i)
      cdq_pkg::OP_HOLD:       data_d = data_q;
      cdq_pkg::OP_TAKE_LEFT:  data_d = left_i;
      cdq_pkg::OP_TAKE_RIGHT: data_d = right_i;
      cdq_pkg::OP_LOAD_TAIL: begin
        if (count_i == MyIdx) begin
          data_d = value_i;
        end
      end
      default:                data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // rear element rides the chain as a masked or
  assign is_tail = (count_i == NextIdx);
  assign tail_o  = tail_i | (data_q & {DATA_WIDTH{is_tail}});
  assign data_o  = data_q;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DataWidth = cdq_pkg::DefDataWidth;
  localparam int Depth = cdq_pkg::DefDepth;
  localparam int CmdW = cdq_pkg::CmdWidth;
  localparam int AddrW = cdq_pkg::ApbAddrWidth;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 3;

  localparam logic [CmdW-1:0] CmdUnusedLo = 3'd6;
  localparam logic [CmdW-1:0] CmdUnusedHi = 3'd7;
  localparam logic [AddrW-1:0] AddrCapacity = AddrW'(4 * int'(cdq_pkg::REG_CAPACITY));

  typedef struct packed {
    logic                 ok;
    logic [DataWidth-1:0] value;
    cdq_pkg::status_e     status;
    logic                 empty;
    logic                 full;
  } deque_result_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             start_i = 1'b0;
  logic                             busy_o;
  logic [CmdW-1:0]                  cmd_i = '0;
  logic [DataWidth-1:0]             value_in_i = '0;
  logic                             done_o;
  logic                             ok_o;
  logic [DataWidth-1:0]             value_out_o;
  logic [cdq_pkg::StatusWidth-1:0]  status_o;
  logic                             is_empty_o;
  logic                             is_full_o;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [AddrW-1:0]                 paddr = '0;
  logic [cdq_pkg::ApbDataWidth-1:0] pwdata = '0;
  logic [cdq_pkg::ApbDataWidth-1:0] prdata;
  logic                             pready;

  circular_deque_core #(
    .DATA_WIDTH(DataWidth),
    .DEPTH     (Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .value_in_i (value_in_i),
    .done_o     (done_o),
    .ok_o       (ok_o),
    .value_out_o(value_out_o),
    .status_o   (status_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // shadow deque state
  logic [DataWidth-1:0]         dq_store[Depth];
  logic [3:0]                   dq_front;
  logic [3:0]                   dq_rear;
  logic                         dq_empty;
  logic [cdq_pkg::CapWidth-1:0] dq_capacity;

  deque_result_t pending_results[$];
  int  n_errors = 0;
  int  n_requests = 0;
  int  n_cap_writes = 0;
  int  n_refused_full = 0;
  int  n_refused_empty = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  function automatic int used_capacity();
    if (dq_capacity == 0) return 1;
    if (int'(dq_capacity) > Depth) return Depth;
    return int'(dq_capacity);
  endfunction

  function automatic logic [3:0] step_up(logic [3:0] idx);
    return (int'(idx) + 1 >= used_capacity()) ? 4'd0 : idx + 4'd1;
  endfunction

  function automatic logic [3:0] step_down(logic [3:0] idx);
    return (idx == 0) ? 4'(used_capacity() - 1) : idx - 4'd1;
  endfunction

  function automatic logic deque_is_full();
    return !dq_empty && step_up(dq_rear) == dq_front;
  endfunction

  function automatic void clear_deque();
    dq_front = '0;
    dq_rear = '0;
    dq_empty = 1'b1;
  endfunction

  function automatic deque_result_t predict_deque_op(logic [CmdW-1:0] cmd,
                                                     logic [DataWidth-1:0] val);
    deque_result_t res;
    res = '{ok: 1'b0, value: '0, status: cdq_pkg::ST_DONE, empty: 1'b0, full: 1'b0};
    if (int'(dq_front) >= used_capacity()) dq_front = '0;
    if (int'(dq_rear) >= used_capacity()) dq_rear = '0;
    case (cmd)
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_REAR: begin
        if (deque_is_full()) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          if (dq_empty) begin
            dq_front = '0;
            dq_rear = '0;
            dq_empty = 1'b0;
            dq_store[0] = val;
          end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
            dq_front = step_down(dq_front);
            dq_store[dq_front] = val;
          end else begin
            dq_rear = step_up(dq_rear);
            dq_store[dq_rear] = val;
          end
          res.ok = 1'b1;
        end
      end
      cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_REAR: begin
        if (dq_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.value = dq_store[cmd == cdq_pkg::CMD_POP_FRONT ? dq_front : dq_rear];
          if (dq_front == dq_rear) begin
            clear_deque();
          end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
            dq_front = step_up(dq_front);
          end else begin
            dq_rear = step_down(dq_rear);
          end
          res.ok = 1'b1;
        end
      end
      cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_REAR: begin
        if (dq_empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.value = dq_store[cmd == cdq_pkg::CMD_PEEK_FRONT ? dq_front : dq_rear];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.empty = dq_empty;
    res.full = deque_is_full();
    if (res.status == cdq_pkg::ST_FULL) n_refused_full++;
    if (res.status == cdq_pkg::ST_EMPTY) n_refused_empty++;
    return res;
  endfunction

  task automatic check_field(string name, logic [DataWidth-1:0] exp, logic [DataWidth-1:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    deque_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result strobe with no request waiting");
        n_errors++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("ok", DataWidth'(exp_res.ok), DataWidth'(ok_o));
        check_field("value_out", exp_res.value, value_out_o);
        check_field("status", DataWidth'(exp_res.status), DataWidth'(status_o));
        check_field("is_empty", DataWidth'(exp_res.empty), DataWidth'(is_empty_o));
        check_field("is_full", DataWidth'(exp_res.full), DataWidth'(is_full_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL circular_deque_core");
      $finish;
    end
  end

  task automatic idle_gap(int cycles);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic send_request(logic [CmdW-1:0] cmd, logic [DataWidth-1:0] val);
    if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 5));
    @(negedge clk_i);
    start_i <= 1'b1;
    cmd_i <= cmd;
    value_in_i <= val;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(predict_deque_op(cmd, val));
    n_requests++;
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [cdq_pkg::ApbDataWidth-1:0] data);
    wait_drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrCapacity;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dq_capacity = data[cdq_pkg::CapWidth-1:0];
    clear_deque();
    n_cap_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [DataWidth-1:0] pick_value();
    case ($urandom_range(0, 15))
      0: return {1'b1, {(DataWidth-1){1'b0}}};
      1: return {1'b0, {(DataWidth-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return DataWidth'($urandom());
    endcase
  endfunction

  // refusals and unused commands straight out of reset
  task automatic test_empty_refusals();
    send_request(cdq_pkg::CMD_PEEK_FRONT, pick_value());
    send_request(cdq_pkg::CMD_PEEK_REAR, pick_value());
    send_request(cdq_pkg::CMD_POP_FRONT, pick_value());
    send_request(cdq_pkg::CMD_POP_REAR, pick_value());
    send_request(CmdUnusedLo, 32'hFFFF_FFFF);
    send_request(CmdUnusedHi, 32'h0000_0000);
  endtask

  // pushes at both ends, full refusal, last element popped, pop on empty
  task automatic test_small_capacity();
    write_capacity(32'd2);
    send_request(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(cdq_pkg::CMD_PUSH_REAR, 32'h7FFF_FFFF);
    send_request(cdq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(cdq_pkg::CMD_PEEK_FRONT, 32'h0);
    send_request(cdq_pkg::CMD_PEEK_REAR, 32'h0);
    send_request(cdq_pkg::CMD_POP_REAR, 32'h0);
    send_request(cdq_pkg::CMD_POP_FRONT, 32'h0);
    send_request(cdq_pkg::CMD_POP_FRONT, 32'h0);
  endtask

  // zero acts as one, above depth acts as depth, write clears contents
  task automatic test_capacity_range();
    write_capacity(32'd0);
    send_request(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
    send_request(cdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
    send_request(cdq_pkg::CMD_PEEK_REAR, 32'h0);
    send_request(cdq_pkg::CMD_POP_REAR, 32'h0);
    send_request(cdq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    write_capacity(32'hFFFF_FFF1);
    send_request(cdq_pkg::CMD_POP_FRONT, 32'h0);
    send_request(cdq_pkg::CMD_PUSH_REAR, 32'hAAAA_AAAA);
    send_request(cdq_pkg::CMD_POP_FRONT, 32'h0);
  endtask

  task automatic random_phase(int items, bit drain_midway);
    int push_pct;
    int r;
    logic [CmdW-1:0] cmd;
    for (int i = 0; i < items; i++) begin
      // alternate fill and drain stretches so full and empty both come up
      push_pct = ((i / 40) % 2 == 0) ? 80 : 25;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        cmd = $urandom_range(0, 1) ? CmdUnusedHi : CmdUnusedLo;
      end else if (r < push_pct) begin
        cmd = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_REAR : cdq_pkg::CMD_PUSH_FRONT;
      end else begin
        cmd = CmdW'($urandom_range(int'(cdq_pkg::CMD_POP_FRONT),
                                   int'(cdq_pkg::CMD_PEEK_REAR)));
      end
      send_request(cmd, pick_value());
      if (drain_midway && i == items / 2) wait_drain();
    end
  endtask

  task automatic test_random_traffic();
    logic [cdq_pkg::ApbDataWidth-1:0] cap;
    for (int p = 0; p < 12; p++) begin
      case (p)
        0: cap = 32'd16;
        1: cap = 32'd1;
        2: cap = 32'd3;
        3: cap = 32'd31;
        4: cap = 32'd0;
        5: cap = 32'd17;
        default: cap = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(1, 16));
      endcase
      write_capacity(cap);
      gaps_on = (p < 10);
      random_phase(100, p == 3);
    end
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) dq_store[i] = '0;
    dq_capacity = cdq_pkg::CapReset;
    clear_deque();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_refusals();
    test_small_capacity();
    test_capacity_range();
    test_random_traffic();

    wait_drain();
    $display("covered %0d requests over %0d capacity writes", n_requests, n_cap_writes);
    $display("refusals seen: %0d push on full, %0d pop or peek on empty",
             n_refused_full, n_refused_empty);
    if (n_errors == 0) begin
      $display("PASS circular_deque_core");
    end else begin
      $display("FAIL circular_deque_core");
    end
    $finish;
  end

endmodule
